### hdl/idle_interval_subtractor_unit_defines.svh
// Assertion macros for the idle interval subtractor.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef IDLE_INTERVAL_SUBTRACTOR_UNIT_DEFINES_SVH
`define IDLE_INTERVAL_SUBTRACTOR_UNIT_DEFINES_SVH

// Clocked property, switched off while reset is held.
`define IISU_ASSERT_IMPL(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Condition that must never be seen.
`define IISU_ASSERT_NEVER(lbl, cond, msg) \
    `IISU_ASSERT_IMPL(lbl, !(cond), msg)

`endif

### hdl/iisu_pkg.sv
// Shared types and constants of the idle interval subtractor.
// No dependencies.
`default_nettype none

package iisu_pkg;

    localparam int DATA_W = 32;

    localparam logic OP_CLEAR  = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;     // latch input word, start a new item
        logic clear;    // list becomes [0, end_time]
        logic prime;    // read entry 0
        logic step;     // process the entry on the read port
        logic append;   // write the right piece of a split
        logic finish;   // load the result register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_clear;
        logic walk_empty;
        logic need_append;
        logic last_entry;
        logic more_entries;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

### hdl/idle_interval_subtractor_unit.sv
// Top level of the idle interval subtractor: controller, datapath, assertions.
// Depends on iisu_pkg, iisu_ctrl, iisu_datapath and the assertion macro header.
//
// Usage
//   cfg channel : cfg_valid/cfg_ready/cfg_data writes end_time (always ready).
//                 Write only while the block is idle.
//   s_ channel  : one word per item. tuser = operation (0 clear, 1 remove),
//                 tdata = {range_end, range_start}.
//   m_ channel  : one word per item. tdata = free_time, tuser = list_full.
// Timing
//   One item at a time. A clear goes from acceptance through dispatch and
//   the done state to the result. A remove walks the N entries listed,
//   N being the list length on arrival; the walk reads one stored interval
//   per cycle through the store's single read port, except where an append
//   comes between: each split that appends a piece takes the write port in a
//   state of its own. Appends only fill free slots, so walk plus appends never pass MAX_INTERVALS.
// Reset
//   Synchronous, active low: list empty, end_time 0, no result pending.
//   The interval store is not cleared; only listed entries are ever read.
// Stalls
//   The result register holds its word until m_tready; the next item is
//   accepted meanwhile and waits in its last step until the register frees.
`default_nettype none

`include "idle_interval_subtractor_unit_defines.svh"

module idle_interval_subtractor_unit #(
    parameter int MAX_INTERVALS = 128
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration: end_time
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [31:0] range_start, [63:32] range_end
    input  wire logic [0:0]  s_tuser,   // [0] operation
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] free_time
    output logic [0:0]       m_tuser    // [0] list_full
);

    iisu_pkg::cmd_t    cmd;
    iisu_pkg::status_t status;

    // register write needs no back-pressure
    assign cfg_ready = 1'b1;

    iisu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    iisu_datapath #(
        .MAX_INTERVALS (MAX_INTERVALS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_op     (s_tuser[0]),
        .in_start  (s_tdata[31:0]),
        .in_end    (s_tdata[63:32]),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_free  (m_tdata),
        .out_full  (m_tuser[0])
    );

    // an accepted word closes the input until its result is produced
    `IISU_ASSERT_IMPL(a_one_item_at_a_time, (s_tvalid && s_tready) |=> !s_tready, "taken while busy")
    // the result register is never overwritten while its word is still held
    `IISU_ASSERT_IMPL(a_result_slot_free, cmd.finish |-> status.out_free, "result overwritten")
    // an append cycle only follows a split with room in the list
    `IISU_ASSERT_IMPL(a_append_after_split, cmd.append |-> $past(status.need_append), "stray append")

endmodule

`default_nettype wire

### hdl/iisu_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module iisu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hdl/iisu_ctrl.sv
// Sequencing state machine of the idle interval subtractor.
// Depends on iisu_pkg.
`default_nettype none

module iisu_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire iisu_pkg::status_t status,
    output iisu_pkg::cmd_t         cmd
);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_DISPATCH = 5'b00010,
        ST_WALK     = 5'b00100,
        ST_APPEND   = 5'b01000,
        ST_DONE     = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (status.is_clear) begin
                    cmd.clear  = 1'b1;
                    state_next = ST_DONE;
                end else if (status.walk_empty) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.prime  = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                cmd.step = 1'b1;
                if (status.need_append) begin
                    state_next = ST_APPEND;
                end else if (status.last_entry) begin
                    state_next = ST_DONE;
                end
            end
            ST_APPEND: begin
                cmd.append = 1'b1;
                state_next = status.more_entries ? ST_WALK : ST_DONE;
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### hdl/iisu_datapath.sv
// Datapath: interval store, per-entry trim/split logic, running sum, result register.
// Depends on iisu_pkg and iisu_ram.
`default_nettype none

module iisu_datapath #(
    parameter int MAX_INTERVALS = 128
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    input  wire logic [iisu_pkg::DATA_W-1:0]   cfg_data,
    input  wire logic                          in_op,
    input  wire logic [iisu_pkg::DATA_W-1:0]   in_start,
    input  wire logic [iisu_pkg::DATA_W-1:0]   in_end,
    input  wire iisu_pkg::cmd_t                cmd,
    output iisu_pkg::status_t                  status,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [iisu_pkg::DATA_W-1:0]        out_free,
    output logic                               out_full
);

    localparam int DW = iisu_pkg::DATA_W;
    localparam int CW = $clog2(MAX_INTERVALS + 1);
    localparam int IW = $clog2(MAX_INTERVALS);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_INTERVALS);

    logic [DW-1:0] end_time_reg, end_time_next;
    logic          op_reg, op_next;
    logic [DW-1:0] a_reg, a_next;
    logic [DW-1:0] b_reg, b_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] walk_reg, walk_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [DW-1:0] sum_reg, sum_next;
    logic          full_reg, full_next;
    logic [DW-1:0] app_e_reg, app_e_next;
    logic          out_valid_reg, out_valid_next;
    logic [DW-1:0] out_free_reg, out_free_next;
    logic          out_full_reg, out_full_next;

    logic              wr_en, rd_en;
    logic [IW-1:0]     wr_addr, rd_addr;
    logic [2*DW-1:0]   wr_data, rd_data;

    logic [DW-1:0] ent_s, ent_e, new_s, new_e;
    logic          start_in, end_in, covered, split, need_append, dropped;
    logic [CW-1:0] idx_plus;

    iisu_ram #(
        .WIDTH (2 * DW),
        .DEPTH (MAX_INTERVALS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // entry on the read port: {end, start}
    assign ent_s    = rd_data[DW-1:0];
    assign ent_e    = rd_data[2*DW-1:DW];
    assign idx_plus = idx_reg + CW'(1);

    always_comb begin
        start_in = (a_reg > ent_s) && (a_reg < ent_e);
        end_in   = (b_reg > ent_s) && (b_reg < ent_e);
        covered  = (a_reg <= ent_s) && (b_reg >= ent_e);
        split    = start_in && (b_reg < ent_e);
        new_s    = ent_s;
        new_e    = ent_e;
        if (start_in) begin
            new_e = a_reg;
        end else if (end_in) begin
            new_s = b_reg;
        end else if (covered) begin
            new_e = ent_s;     // emptied
        end
        need_append = split && (count_reg < MAX_CNT);
        dropped     = split && (count_reg >= MAX_CNT);
    end

    // store port control
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = idx_reg[IW-1:0];
        wr_data = {new_e, new_s};
        rd_en   = 1'b0;
        rd_addr = idx_plus[IW-1:0];
        if (cmd.clear) begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = {end_time_reg, {DW{1'b0}}};
        end else if (cmd.prime) begin
            rd_en   = 1'b1;
            rd_addr = '0;
        end else if (cmd.step) begin
            wr_en = 1'b1;
            rd_en = !need_append && (idx_plus != walk_reg);
        end else if (cmd.append) begin
            wr_en   = 1'b1;
            wr_addr = count_reg[IW-1:0];
            wr_data = {app_e_reg, b_reg};
            rd_en   = (idx_reg != walk_reg);
            rd_addr = idx_reg[IW-1:0];
        end
    end

    always_comb begin
        end_time_next  = cfg_valid ? cfg_data : end_time_reg;
        op_next        = op_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        count_next     = count_reg;
        walk_next      = walk_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        full_next      = full_reg;
        app_e_next     = app_e_reg;
        out_free_next  = out_free_reg;
        out_full_next  = out_full_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cmd.load) begin
            op_next   = in_op;
            a_next    = in_start;
            b_next    = in_end;
            walk_next = count_reg;
            idx_next  = '0;
            sum_next  = '0;
            full_next = 1'b0;
        end
        if (cmd.clear) begin
            count_next = CW'(1);
            sum_next   = end_time_reg;
        end
        if (cmd.step) begin
            idx_next   = idx_plus;
            sum_next   = sum_reg + (new_e - new_s);
            app_e_next = ent_e;
            if (dropped) begin
                full_next = 1'b1;
            end
        end
        if (cmd.append) begin
            count_next = count_reg + CW'(1);
            sum_next   = sum_reg + (app_e_reg - b_reg);
        end
        if (cmd.finish) begin
            out_valid_next = 1'b1;
            out_free_next  = sum_reg;
            out_full_next  = full_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            end_time_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            end_time_reg  <= end_time_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
        op_reg       <= op_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        walk_reg     <= walk_next;
        idx_reg      <= idx_next;
        sum_reg      <= sum_next;
        full_reg     <= full_next;
        app_e_reg    <= app_e_next;
        out_free_reg <= out_free_next;
        out_full_reg <= out_full_next;
    end

    always_comb begin
        status.is_clear     = (op_reg == iisu_pkg::OP_CLEAR);
        status.walk_empty   = (walk_reg == '0);
        status.need_append  = need_append;
        status.last_entry   = (idx_plus == walk_reg);
        status.more_entries = (idx_reg != walk_reg);
        status.out_free     = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_free  = out_free_reg;
    assign out_full  = out_full_reg;

endmodule

`default_nettype wire
